@@ rtl/pidci_pkg.sv @@
// ----------------------------------------------------------------------------
// pidci_pkg: shared types and constants of the PID controller block
// Widths of the data path, register indexes and controller states.
// ----------------------------------------------------------------------------
package pidci_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int LIMIT_BITS = 23;

	localparam int ACC_W  = LIMIT_BITS + 1;
	localparam int ERR_W  = DATA_WIDTH + 1;
	localparam int DIFF_W = DATA_WIDTH + 2;
	localparam int TERM_W = ((ACC_W > DIFF_W) ? ACC_W : DIFF_W) + 2;
	localparam int HI_W   = TERM_W + 2;
	localparam int SUM_W  = HI_W + DATA_WIDTH - 1;
	localparam int CNT_W  = $clog2(DATA_WIDTH);
	localparam int CFG_W  = (DATA_WIDTH > LIMIT_BITS) ? DATA_WIDTH : LIMIT_BITS;
	localparam int IDX_W  = 3;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ERR_W-1:0]      err_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic signed [TERM_W-1:0]     term_t;
	typedef logic signed [HI_W-1:0]       part_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic [LIMIT_BITS-1:0]        lim_t;
	typedef logic [CFG_W-1:0]             cfg_data_t;
	typedef logic [IDX_W-1:0]             cfg_idx_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DRIVE_MIN,
		REG_DRIVE_MAX,
		REG_INT_LIMIT
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MAC,
		ST_CHECK,
		ST_OUT
	} state_t;

endpackage

@@ rtl/pidci_if.sv @@
// ----------------------------------------------------------------------------
// pidci_if: valid/ready channels of the PID controller block
// One channel carries measurements in, the other carries drive results out.
// ----------------------------------------------------------------------------
interface pidci_meas_if;
	logic              valid;
	logic              ready;
	pidci_pkg::data_t  measurement;

	modport source (output valid, output measurement, input ready);
	modport sink   (input valid, input measurement, output ready);
endinterface

interface pidci_drive_if;
	logic              valid;
	logic              ready;
	pidci_pkg::data_t  drive;
	logic              saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink   (input valid, input drive, input saturated, output ready);
endinterface

@@ rtl/pidci_mac.sv @@
// ----------------------------------------------------------------------------
// pidci_mac: bit-serial three-gain multiply-accumulate
// Forms gain_p*err + gain_d*diff + gain_i*accum exactly, taking one bit of
// each gain per cycle, LSB first; the gain MSB carries negative weight.
// ----------------------------------------------------------------------------
module pidci_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pidci_pkg::data_t  gain_p,
	input  pidci_pkg::data_t  gain_i,
	input  pidci_pkg::data_t  gain_d,
	input  pidci_pkg::err_t   err,
	input  pidci_pkg::diff_t  diff,
	input  pidci_pkg::acc_t   accum,
	output logic              done,
	output pidci_pkg::sum_t   sum
);
	import pidci_pkg::*;

	logic [DATA_WIDTH-1:0] gp_q, gi_q, gd_q;
	part_t                 hi_q;
	logic [DATA_WIDTH-2:0] lo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	sum_t                  sum_q;

	term_t term;
	part_t step;
	logic  last;

	always_comb begin
		term = (gp_q[0] ? term_t'(err)   : '0)
		     + (gd_q[0] ? term_t'(diff)  : '0)
		     + (gi_q[0] ? term_t'(accum) : '0);
		last = (cnt_q == CNT_W'(DATA_WIDTH - 1));
		// the gain sign bit weighs -2^(n-1): subtract on the final step
		step = last ? (hi_q - part_t'(term)) : (hi_q + part_t'(term));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gp_q <= gain_p;
			gi_q <= gain_i;
			gd_q <= gain_d;
			hi_q <= '0;
		end else if (busy_q) begin
			if (last) begin
				sum_q <= {step, lo_q};
			end else begin
				// retire one low bit of the partial sum, advance the gains
				hi_q <= step >>> 1;
				lo_q <= {step[0], lo_q[DATA_WIDTH-2:1]};
				gp_q <= gp_q >> 1;
				gi_q <= gi_q >> 1;
				gd_q <= gd_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign sum  = sum_q;

endmodule

@@ rtl/pid_with_conditional_integration_unit.sv @@
// ----------------------------------------------------------------------------
// pid_with_conditional_integration_unit: PID controller with anti-windup
// Error, difference and integral terms through a bit-serial MAC; the error is
// integrated only when the trial drive lies strictly inside the limits.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one measurement beat per control tick (valid/ready).
//   result : one beat per measurement with the saturated drive and a flag
//            that is high when the drive was clamped to a limit.
//   cfg_*  : write port for target, gains, drive limits and integral limit;
//            write only while the block is idle. A gain write clears the
//            integral sum and the previous error.
// Timing: the MAC takes one gain bit per cycle. A tick without integration
//   runs one pass before its result is loaded into the output register; a
//   tick that integrates runs a second pass first. The block is ready for
//   the next measurement in the cycle after the result is loaded.
// Reset: state, settings, integral sum, previous error, result valid clear.
// Stall: the result waits in an output register while the next measurement
//   is taken and processed; a finished result then holds until it drains.
// ----------------------------------------------------------------------------
module pid_with_conditional_integration_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  pidci_pkg::cfg_idx_t    cfg_index,
	input  pidci_pkg::cfg_data_t   cfg_data,
	pidci_meas_if.sink             sample,
	pidci_drive_if.source          result
);
	import pidci_pkg::*;

	typedef logic signed [ACC_W:0] accx_t;

	state_t state_q, state_d;

	data_t target_q, gain_p_q, gain_i_q, gain_d_q, drive_min_q, drive_max_q;
	lim_t  int_limit_q;

	data_t meas_q;
	err_t  err_q, prev_q;
	diff_t diff_q;
	acc_t  acc_q;
	logic  pass2_q;

	logic  res_valid_q;
	data_t drive_q;
	logic  sat_q;

	logic  mac_start, mac_done;
	sum_t  mac_sum;

	err_t  err_d;
	diff_t diff_d;
	sum_t  drv_full, lo_ext, hi_ext;
	logic  in_limits, above_hi, below_lo;
	data_t drv_final;
	accx_t acc_sum, lim_pos, lim_neg, acc_new;
	logic  gain_wr, in_take, do_integ, out_load;

	pidci_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.err    (err_q),
		.diff   (diff_q),
		.accum  (acc_q),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	// data path
	always_comb begin
		err_d  = err_t'(target_q) - err_t'(meas_q);
		diff_d = diff_t'(prev_q) - diff_t'(err_d);

		drv_full  = mac_sum >>> FRAC_BITS;
		lo_ext    = sum_t'(drive_min_q);
		hi_ext    = sum_t'(drive_max_q);
		in_limits = (drv_full > lo_ext) && (drv_full < hi_ext);
		above_hi  = drv_full > hi_ext;
		// upper clamp first, then lower
		below_lo = above_hi ? (drive_max_q < drive_min_q) : (drv_full < lo_ext);
		if (below_lo)
			drv_final = drive_min_q;
		else if (above_hi)
			drv_final = drive_max_q;
		else
			drv_final = drv_full[DATA_WIDTH-1:0];

		acc_sum = accx_t'(acc_q) + accx_t'(err_q);
		lim_pos = accx_t'(int_limit_q);
		lim_neg = -lim_pos;
		if (acc_sum > lim_pos)
			acc_new = lim_pos;
		else if (acc_sum < lim_neg)
			acc_new = lim_neg;
		else
			acc_new = acc_sum;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (sample.valid) state_d = ST_ERR;
			ST_ERR:   state_d = ST_MAC;
			ST_MAC:   if (mac_done) state_d = ST_CHECK;
			ST_CHECK: state_d = (!pass2_q && in_limits) ? ST_MAC : ST_OUT;
			ST_OUT:   if (!res_valid_q || result.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		in_take   = 1'b0;
		do_integ  = 1'b0;
		mac_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_take = sample.valid;
			ST_ERR:   mac_start = 1'b1;
			ST_CHECK: begin
				do_integ  = !pass2_q && in_limits;
				mac_start = !pass2_q && in_limits;
			end
			ST_OUT:   out_load = !res_valid_q || result.ready;
			default:  ;
		endcase
	end

	assign gain_wr = cfg_we && (cfg_index inside {REG_GAIN_P, REG_GAIN_I, REG_GAIN_D});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			drive_min_q <= '0;
			drive_max_q <= '0;
			int_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:    target_q    <= cfg_data[DATA_WIDTH-1:0];
				REG_GAIN_P:    gain_p_q    <= cfg_data[DATA_WIDTH-1:0];
				REG_GAIN_I:    gain_i_q    <= cfg_data[DATA_WIDTH-1:0];
				REG_GAIN_D:    gain_d_q    <= cfg_data[DATA_WIDTH-1:0];
				REG_DRIVE_MIN: drive_min_q <= cfg_data[DATA_WIDTH-1:0];
				REG_DRIVE_MAX: drive_max_q <= cfg_data[DATA_WIDTH-1:0];
				REG_INT_LIMIT: int_limit_q <= cfg_data[LIMIT_BITS-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			prev_q  <= '0;
			pass2_q <= 1'b0;
		end else begin
			if (gain_wr) begin
				acc_q  <= '0;
				prev_q <= '0;
			end else if (state_q == ST_ERR) begin
				prev_q <= err_d;
			end else if (do_integ) begin
				acc_q <= acc_new[ACC_W-1:0];
			end
			if (state_q == ST_ERR)
				pass2_q <= 1'b0;
			else if (do_integ)
				pass2_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			meas_q <= sample.measurement;
		if (state_q == ST_ERR) begin
			err_q  <= err_d;
			diff_q <= diff_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_q <= drv_final;
			sat_q   <= above_hi || below_lo;
		end
	end

	assign sample.ready     = (state_q == ST_IDLE);
	assign result.valid     = res_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

	a_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_MAC)
		else $error("MAC finished outside of the MAC state");

	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(do_integ && !gain_wr) |=> (accx_t'(acc_q) <= lim_pos && accx_t'(acc_q) >= lim_neg))
		else $error("integral sum outside its limit after integration");

	a_one_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && pass2_q) |=> state_q == ST_OUT)
		else $error("second pass did not end the tick");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!res_valid_q || result.ready))
		else $error("pending result overwritten");

endmodule

@@ dv/pid_with_conditional_integration_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pid_with_conditional_integration_unit_tb: self-checking bench of the PID unit
// Drives measurement beats, predicts drive and saturation flag per beat with a
// behavioral controller model, and compares every drive beat in order. Runs
// directed corner cases, a long receiver hold-off and many randomized phases.
// ----------------------------------------------------------------------------
module pid_with_conditional_integration_unit_tb;
	import pidci_pkg::*;

	localparam int       QUIET_LIMIT = 3000;
	localparam int       PARK_LEN    = 300;
	localparam int       END_WAIT    = 50;
	localparam cfg_idx_t IDX_SPARE   = 3'd7;

	typedef struct {
		data_t drive;
		logic  saturated;
	} drive_beat_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;

	pidci_meas_if  meas_ch ();
	pidci_drive_if drive_ch ();

	pid_with_conditional_integration_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (meas_ch),
		.result    (drive_ch)
	);

	// controller model state
	data_t  set_target  = '0;
	data_t  kp          = '0;
	data_t  ki          = '0;
	data_t  kd          = '0;
	data_t  drive_lo    = '0;
	data_t  drive_hi    = '0;
	lim_t   integ_limit = '0;
	longint integ_sum   = 0;
	longint last_err    = 0;
	data_t  last_drive  = '0;

	drive_beat_t drive_q[$];
	drive_beat_t want;
	int          mismatches  = 0;
	int          quiet       = 0;
	int          stall_left  = 0;
	int          park_cycles = 0;
	bit          idle_on     = 1'b0;
	int          plant       = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint pid_sum(longint err, longint diff, longint acc);
		longint s;
		s = longint'(kp) * err + longint'(kd) * diff + longint'(ki) * acc;
		return s >>> FRAC_BITS;
	endfunction

	function automatic drive_beat_t pid_predict(data_t m);
		longint      err, diff, drv, acc, lo, hi, lim;
		drive_beat_t res;
		err      = longint'(set_target) - longint'(m);
		diff     = last_err - err;
		last_err = err;
		lo       = drive_lo;
		hi       = drive_hi;
		lim      = longint'(integ_limit);
		drv      = pid_sum(err, diff, integ_sum);
		// integrate only when the trial is strictly inside the limits
		if (drv > lo && drv < hi) begin
			acc = integ_sum + err;
			if (acc > lim)
				acc = lim;
			if (acc < -lim)
				acc = -lim;
			integ_sum = acc;
			drv       = pid_sum(err, diff, integ_sum);
		end
		res.saturated = 1'b0;
		if (drv > hi) begin
			drv           = hi;
			res.saturated = 1'b1;
		end
		if (drv < lo) begin
			drv           = lo;
			res.saturated = 1'b1;
		end
		res.drive  = data_t'(drv);
		last_drive = res.drive;
		return res;
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, cfg_data_t val);
		case (idx)
			REG_TARGET:    set_target = data_t'(val);
			REG_GAIN_P:    kp = data_t'(val);
			REG_GAIN_I:    ki = data_t'(val);
			REG_GAIN_D:    kd = data_t'(val);
			REG_DRIVE_MIN: drive_lo = data_t'(val);
			REG_DRIVE_MAX: drive_hi = data_t'(val);
			REG_INT_LIMIT: integ_limit = lim_t'(val);
			default: ;
		endcase
		// gain writes restart the integral and the difference history
		if (idx == REG_GAIN_P || idx == REG_GAIN_I || idx == REG_GAIN_D) begin
			integ_sum = 0;
			last_err  = 0;
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint exp_val);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
		mismatches++;
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int tgt, int gp, int gi, int gd, int lo, int hi, int lim);
		write_reg(REG_TARGET, cfg_data_t'(tgt));
		write_reg(REG_GAIN_P, cfg_data_t'(gp));
		write_reg(REG_GAIN_I, cfg_data_t'(gi));
		write_reg(REG_GAIN_D, cfg_data_t'(gd));
		write_reg(REG_DRIVE_MIN, cfg_data_t'(lo));
		write_reg(REG_DRIVE_MAX, cfg_data_t'(hi));
		write_reg(REG_INT_LIMIT, cfg_data_t'(lim));
	endtask

	// offer one beat, predict its drive once it is taken
	task automatic send_meas(data_t m);
		if (idle_on && $urandom_range(0, 15) == 0) begin
			meas_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		meas_ch.valid       <= 1'b1;
		meas_ch.measurement <= m;
		@(posedge clk);
		while (!meas_ch.ready)
			@(posedge clk);
		drive_q.push_back(pid_predict(m));
	endtask

	task automatic wait_drained();
		meas_ch.valid <= 1'b0;
		@(posedge clk);
		while (drive_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic int rand_gain();
		if ($urandom_range(0, 3) == 0)
			return int'(data_t'($urandom));
		return int'($urandom_range(0, 2048)) - 1024;
	endfunction

	task automatic test_field_extremes();
		// all registers at reset: zero gains and equal limits
		send_meas(16'sh7fff);
		send_meas(16'sh8000);
		wait_drained();
		set_config(0, 256, 16, -128, -32768, 32767, 8388607);
		send_meas(16'sh0000);
		send_meas(16'sh7fff);
		send_meas(16'sh8000);
		send_meas(16'shffff);
		wait_drained();
		write_reg(REG_TARGET, cfg_data_t'(-32768));
		send_meas(16'sh7fff);
		wait_drained();
		set_config(32767, -32768, -32768, 32767, -32768, 32767, 8388607);
		send_meas(16'sh8000);
		send_meas(16'sh7fff);
		wait_drained();
	endtask

	task automatic test_boundary_trial();
		set_config(0, 256, 256, 0, -100, 100, 1000);
		send_meas(-16'sd100);
		send_meas(16'sd100);
		send_meas(-16'sd50);
		wait_drained();
	endtask

	task automatic test_inverted_limits();
		set_config(0, 256, 64, 32, 50, -50, 1000);
		send_meas(16'sd0);
		send_meas(-16'sd1000);
		send_meas(16'sd1000);
		wait_drained();
	endtask

	task automatic test_integral_limits();
		// zero bound forces the sum to zero on each integration
		set_config(0, 1, 256, 0, -32768, 32767, 0);
		send_meas(-16'sd5);
		send_meas(-16'sd5);
		wait_drained();
		write_reg(REG_INT_LIMIT, cfg_data_t'(1000));
		send_meas(-16'sd300);
		send_meas(-16'sd300);
		send_meas(-16'sd300);
		wait_drained();
		// lower the bound while the trial sits outside: sum must survive
		write_reg(REG_INT_LIMIT, cfg_data_t'(10));
		write_reg(REG_DRIVE_MAX, cfg_data_t'(5));
		send_meas(-16'sd300);
		wait_drained();
		write_reg(REG_DRIVE_MAX, cfg_data_t'(32767));
		send_meas(-16'sd300);
		wait_drained();
	endtask

	task automatic test_gain_write_clears();
		set_config(0, 128, 64, 512, -32768, 32767, 100000);
		send_meas(-16'sd700);
		send_meas(16'sd300);
		wait_drained();
		write_reg(REG_GAIN_D, cfg_data_t'(512));
		write_reg(IDX_SPARE, 23'h7fffff);
		send_meas(-16'sd200);
		wait_drained();
	endtask

	task automatic test_backpressure();
		set_config(100, 200, 40, -300, -20000, 20000, 50000);
		idle_on     = 1'b0;
		park_cycles = PARK_LEN;
		for (int i = 0; i < 40; i++)
			send_meas(data_t'($urandom_range(0, 400)));
		// sender pause until every drive beat has drained
		wait_drained();
		idle_on = 1'b1;
		for (int i = 0; i < 20; i++)
			send_meas(data_t'($urandom));
		wait_drained();
	endtask

	task automatic shuffle_config(int kind);
		int lo, hi, tmp;
		case (kind)
			0: set_config(32767, 32767, 32767, 32767, 32767, 32767, 8388607);
			1: set_config(-32768, -32768, -32768, -32768, -32768, -32768, 0);
			default: begin
				write_reg(REG_TARGET, $urandom_range(0, 1) ?
					cfg_data_t'($urandom) : cfg_data_t'(int'($urandom_range(0, 4000)) - 2000));
				if ($urandom_range(0, 3) != 0) begin
					write_reg(REG_GAIN_P, cfg_data_t'(rand_gain()));
					write_reg(REG_GAIN_I, cfg_data_t'(rand_gain()));
					write_reg(REG_GAIN_D, cfg_data_t'(rand_gain()));
				end
				lo = -int'($urandom_range(0, 32768));
				hi = int'($urandom_range(0, 32767));
				case ($urandom_range(0, 7))
					0: begin
						tmp = lo;
						lo  = hi;
						hi  = tmp;
					end
					1: begin
						lo = int'(data_t'($urandom));
						hi = int'(data_t'($urandom));
					end
					default: ;
				endcase
				write_reg(REG_DRIVE_MIN, cfg_data_t'(lo));
				write_reg(REG_DRIVE_MAX, cfg_data_t'(hi));
				case ($urandom_range(0, 3))
					0: write_reg(REG_INT_LIMIT, cfg_data_t'(0));
					1: write_reg(REG_INT_LIMIT, cfg_data_t'($urandom_range(1, 4096)));
					2: write_reg(REG_INT_LIMIT, cfg_data_t'($urandom));
					default: write_reg(REG_INT_LIMIT, 23'h7fffff);
				endcase
			end
		endcase
	endtask

	task automatic test_random_phases();
		int    mode;
		data_t m;
		for (int ph = 0; ph < 18; ph++) begin
			shuffle_config(ph);
			// no idling in the closing phases
			idle_on = (ph < 16) && ($urandom_range(0, 3) != 0);
			mode    = $urandom_range(0, 3);
			plant   = int'(set_target);
			for (int i = 0; i < 100; i++) begin
				case (mode)
					0: m = data_t'($urandom);
					1: m = data_t'(int'(set_target) + int'($urandom_range(0, 128)) - 64);
					default: begin
						// closed loop: the plant moves with the last drive
						plant = plant + (int'(last_drive) >>> 3) + int'($urandom_range(0, 16)) - 8;
						if (plant > 32767)
							plant = 32767;
						if (plant < -32768)
							plant = -32768;
						m = data_t'(plant);
					end
				endcase
				send_meas(m);
			end
			wait_drained();
		end
	endtask

	// receiver: random stall bursts plus one long hold-off on request
	always @(posedge clk) begin
		if (park_cycles > 0) begin
			stall_left  = park_cycles;
			park_cycles = 0;
		end else if (stall_left == 0 && idle_on && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(1, 19);
		end
		if (stall_left > 0) begin
			drive_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			drive_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (drive_ch.valid && drive_ch.ready) begin
			if (drive_q.size() == 0) begin
				report_mismatch("drive beat with nothing pending", drive_ch.drive, 0);
			end else begin
				want = drive_q.pop_front();
				if (drive_ch.drive !== want.drive)
					report_mismatch("drive", drive_ch.drive, want.drive);
				if (drive_ch.saturated !== want.saturated)
					report_mismatch("saturated", drive_ch.saturated, want.saturated);
			end
		end
	end

	always @(posedge clk) begin
		if ((meas_ch.valid && meas_ch.ready) || (drive_ch.valid && drive_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("pid_with_conditional_integration_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		meas_ch.valid       = 1'b0;
		meas_ch.measurement = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		idle_on = 1'b1;
		test_boundary_trial();
		test_inverted_limits();
		test_integral_limits();
		test_gain_write_clears();
		test_backpressure();
		test_random_phases();
		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("pid_with_conditional_integration_unit verification clean");
		else
			$display("pid_with_conditional_integration_unit verification failed");
		$finish;
	end

endmodule
